// ===== hw/rtl/multi_key_click_event_detector_assert.svh =====
// Assertion macros for the multi-key click event detector checker.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef MULTI_KEY_CLICK_EVENT_DETECTOR_ASSERT_SVH
`define MULTI_KEY_CLICK_EVENT_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MKCED_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MKCED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mkced_pkg.sv =====
// Shared types and constants for the multi-key click event detector.
// No dependencies; used by mkced_key, the top level, the checker and the testbench.
`default_nettype none

package mkced_pkg;

	localparam int NUM_KEYS = 4;

	// Field widths
	localparam int FLAG_W = 7;
	localparam int CNT_W  = 16;
	localparam int PER_W  = 4;
	localparam int KEY_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Event flag bits
	localparam int EV_HOLD_BIT   = 0;
	localparam int EV_DOWN_BIT   = 1;
	localparam int EV_UP_BIT     = 2;
	localparam int EV_SINGLE_BIT = 3;
	localparam int EV_DOUBLE_BIT = 4;
	localparam int EV_LONG_BIT   = 5;
	localparam int EV_REPEAT_BIT = 6;
	localparam logic [FLAG_W-1:0] EV_HOLD_MASK = 7'h01;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

	// Reset values of the configuration registers
	localparam logic [CNT_W-1:0] LONG_RST   = 16'd200;
	localparam logic [CNT_W-1:0] DOUBLE_RST = 16'd20;
	localparam logic [CNT_W-1:0] REPEAT_RST = 16'd10;
	localparam logic [PER_W-1:0] PERIOD_RST = 4'd2;

	// Timing registers seen by every key
	typedef struct packed {
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] double_ticks;
		logic [CNT_W-1:0] repeat_ticks;
	} key_cfg_t;

	// Per-item control from the top level to each key
	typedef struct packed {
		logic              en;
		logic              tick;
		logic              sample;
		logic              check;
		logic [FLAG_W-1:0] mask;
	} key_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_key_click_event_detector.sv =====
// Four-key click event detector. Takes one item per clock while the input is not stalled. An
// item is held in the input register and then moves to the result register, from which its
// result is presented. The input stalls only while an item waits in the input register behind
// a result that the receiver is stalling. Every key's state is updated in the single cycle an
// item moves from the input register to the result register, so consecutive items see each
// other's effects with no gap. A tick item (func 0) gives hit 0 and key_flags 0; a check item
// (func 1) reports the key's flags before they are cleared. No clearing pass after reset.
`default_nettype none

module multi_key_click_event_detector (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [mkced_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mkced_pkg::CFG_DAT_W-1:0]      cfg_data,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 func,
	input  wire logic [mkced_pkg::NUM_KEYS-1:0]       pin_levels,
	input  wire logic [mkced_pkg::KEY_W-1:0]          key_index,
	input  wire logic [mkced_pkg::FLAG_W-1:0]         event_mask,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      hit,
	output logic [mkced_pkg::FLAG_W-1:0]              key_flags
);

	// Configuration registers
	mkced_pkg::key_cfg_t              cfg_q;
	logic [mkced_pkg::PER_W-1:0]      period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks   <= mkced_pkg::LONG_RST;
			cfg_q.double_ticks <= mkced_pkg::DOUBLE_RST;
			cfg_q.repeat_ticks <= mkced_pkg::REPEAT_RST;
			period_q           <= mkced_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mkced_pkg::CFG_LONG:   cfg_q.long_ticks   <= cfg_data;
				mkced_pkg::CFG_DOUBLE: cfg_q.double_ticks <= cfg_data;
				mkced_pkg::CFG_REPEAT: cfg_q.repeat_ticks <= cfg_data;
				mkced_pkg::CFG_PERIOD: period_q <= cfg_data[mkced_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic                              valid_s1;
	logic                              func_s1;
	logic [mkced_pkg::NUM_KEYS-1:0]    levels_s1;
	logic [mkced_pkg::KEY_W-1:0]       key_s1;
	logic [mkced_pkg::FLAG_W-1:0]      mask_s1;
	logic                              out_valid_q;
	logic                              hit_q;
	logic [mkced_pkg::FLAG_W-1:0]      flags_q;
	logic                              adv;
	logic                              in_acc;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc || adv)
			valid_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1   <= func;
			levels_s1 <= pin_levels;
			key_s1    <= key_index;
			mask_s1   <= event_mask;
		end
	end

	// Sample divider
	logic [mkced_pkg::PER_W-1:0]  div_q;
	logic [mkced_pkg::PER_W-1:0]  div_inc;
	logic                         do_sample;
	logic                         tick;

	assign tick      = adv && !func_s1;
	assign div_inc   = div_q + 1'b1;
	assign do_sample = (div_inc >= period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_q <= '0;
		else if (tick)
			div_q <= do_sample ? '0 : div_inc;
	end

	// Per-key units
	logic [mkced_pkg::FLAG_W-1:0] key_fl [mkced_pkg::NUM_KEYS];

	for (genvar k = 0; k < mkced_pkg::NUM_KEYS; k++) begin : g_key
		mkced_pkg::key_ctl_t ctl;

		assign ctl.en     = adv;
		assign ctl.tick   = !func_s1;
		assign ctl.sample = do_sample;
		assign ctl.check  = func_s1 && (key_s1 == mkced_pkg::KEY_W'(k));
		assign ctl.mask   = mask_s1;

		mkced_key u_key (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cfg     (cfg_q),
			.pressed (!levels_s1[k]),
			.flags   (key_fl[k])
		);
	end

	// Check result for the selected key
	logic [mkced_pkg::FLAG_W-1:0] sel_fl;
	logic                         sel_hit;

	assign sel_fl  = func_s1 ? key_fl[key_s1] : '0;
	assign sel_hit = (sel_fl & mask_s1) != '0;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= sel_hit;
			flags_q <= sel_fl;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign key_flags = flags_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mkced_key.sv =====
// One key: sampled level, press state machine, countdown and event flags.
// Depends on mkced_pkg for flag bits and the control/config structs.
`default_nettype none

module mkced_key (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mkced_pkg::key_ctl_t             ctl,
	input  wire mkced_pkg::key_cfg_t             cfg,
	input  wire logic                            pressed,
	output logic [mkced_pkg::FLAG_W-1:0]         flags
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_PRESSED = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_SECOND  = 3'd3;
	localparam logic [2:0] PH_REPEAT  = 3'd4;

	logic                          down_q;
	logic [2:0]                    phase_q;
	logic [mkced_pkg::CNT_W-1:0]   cnt_q;
	logic [mkced_pkg::FLAG_W-1:0]  flags_q;

	logic                          down_n;
	logic [2:0]                    phase_n;
	logic [mkced_pkg::CNT_W-1:0]   cnt_n;
	logic [mkced_pkg::FLAG_W-1:0]  flags_n;
	logic [mkced_pkg::CNT_W-1:0]   cnt_dec;

	assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

	// Next state for one item
	always_comb begin
		down_n  = down_q;
		phase_n = phase_q;
		cnt_n   = cnt_q;
		flags_n = flags_q;
		if (ctl.tick) begin
			cnt_n = cnt_dec;
			if (ctl.sample) begin
				down_n = pressed;
				flags_n[mkced_pkg::EV_HOLD_BIT] = pressed;
				if (pressed && !down_q)
					flags_n[mkced_pkg::EV_DOWN_BIT] = 1'b1;
				if (!pressed && down_q)
					flags_n[mkced_pkg::EV_UP_BIT] = 1'b1;
				case (phase_q)
					PH_PRESSED: begin
						if (!pressed) begin
							cnt_n   = cfg.double_ticks;
							phase_n = PH_WAIT;
						end else if (cnt_dec == '0) begin
							cnt_n   = cfg.repeat_ticks;
							flags_n[mkced_pkg::EV_LONG_BIT] = 1'b1;
							phase_n = PH_REPEAT;
						end
					end
					PH_WAIT: begin
						if (pressed) begin
							flags_n[mkced_pkg::EV_DOUBLE_BIT] = 1'b1;
							phase_n = PH_SECOND;
						end else if (cnt_dec == '0) begin
							flags_n[mkced_pkg::EV_SINGLE_BIT] = 1'b1;
							phase_n = PH_IDLE;
						end
					end
					PH_SECOND: begin
						if (!pressed)
							phase_n = PH_IDLE;
					end
					PH_REPEAT: begin
						if (!pressed) begin
							phase_n = PH_IDLE;
						end else if (cnt_dec == '0) begin
							cnt_n   = cfg.repeat_ticks;
							flags_n[mkced_pkg::EV_REPEAT_BIT] = 1'b1;
						end
					end
					default: begin
						if (pressed) begin
							cnt_n   = cfg.long_ticks;
							phase_n = PH_PRESSED;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				endcase
			end
		end else if (ctl.check) begin
			// Clear the tested flags, except on a hold-only query
			if (((flags_q & ctl.mask) != '0) && (ctl.mask != mkced_pkg::EV_HOLD_MASK))
				flags_n = flags_q & ~ctl.mask;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q  <= 1'b0;
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			flags_q <= '0;
		end else if (ctl.en) begin
			down_q  <= down_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			flags_q <= flags_n;
		end
	end

	assign flags = flags_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mkced_checker.sv =====
// Port-level checker for the multi-key click event detector, bound to the top level.
// Depends on multi_key_click_event_detector_assert.svh for the assertion macros.
`default_nettype none

`include "multi_key_click_event_detector_assert.svh"

module mkced_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          hit,
	input wire logic [mkced_pkg::FLAG_W-1:0]  key_flags
);

	// A waiting result holds
	`MKCED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(key_flags), "stalled result changed")

	// A hit needs at least one flag reported
	`MKCED_ASSERT_SAME(a_hit_flags, out_valid && hit, key_flags != '0, "hit with no flags")

	// Input stalls only when the result side is blocked
	`MKCED_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

	// A fresh result follows an item that passed through the input register
	`MKCED_ASSERT_SAME(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an item")

endmodule

bind multi_key_click_event_detector mkced_checker u_mkced_checker (.*);

`default_nettype wire

// ===== dv/multi_key_click_event_detector_test.sv =====
// Self-checking testbench for the four-key click event detector: queued items are driven
// through the valid/stall channel with random bursts and stalls, and every result is
// checked against an in-bench prediction of the key state machines. Needs mkced_pkg.
module multi_key_click_event_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mkced_pkg::*;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;
	localparam logic [FLAG_W-1:0] ALL_FLAGS = '1;
	localparam logic [FLAG_W-1:0] DOWN_FLAG = FLAG_W'(1) << EV_DOWN_BIT;
	localparam logic [FLAG_W-1:0] UP_FLAG = FLAG_W'(1) << EV_UP_BIT;
	localparam logic [FLAG_W-1:0] SINGLE_FLAG = FLAG_W'(1) << EV_SINGLE_BIT;
	localparam logic [FLAG_W-1:0] DOUBLE_FLAG = FLAG_W'(1) << EV_DOUBLE_BIT;
	localparam realtime RUN_LIMIT = 8ms;

	typedef enum logic [2:0] {
		PH_IDLE, PH_PRESSED, PH_WAIT_SECOND, PH_SECOND_HELD, PH_REPEATING
	} press_phase_e;

	typedef struct packed {
		logic                func;
		logic [NUM_KEYS-1:0] pins;
		logic [KEY_W-1:0]    key;
		logic [FLAG_W-1:0]   mask;
	} click_item_t;

	typedef struct packed {
		logic              hit;
		logic [FLAG_W-1:0] key_flags;
	} click_result_t;

	// DUT connections
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DAT_W-1:0]  cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = 1'b0;
	logic [NUM_KEYS-1:0]   pin_levels = '1;
	logic [KEY_W-1:0]      key_index = '0;
	logic [FLAG_W-1:0]     event_mask = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  hit;
	logic [FLAG_W-1:0]     key_flags;

	// predicted block state and register settings
	logic [CNT_W-1:0]      long_ticks, double_ticks, repeat_ticks;
	logic [PER_W-1:0]      period_setting;
	logic [PER_W-1:0]      divider;
	logic                  prev_pressed [NUM_KEYS];
	press_phase_e          key_phase [NUM_KEYS];
	logic [CNT_W-1:0]      cnt_left [NUM_KEYS];
	logic [FLAG_W-1:0]     key_events [NUM_KEYS];

	// item and result bookkeeping
	click_item_t           pending_items [$];
	click_result_t         flags_expected [$];
	click_item_t           drive_item;
	click_result_t         want;
	logic                  item_taken = 1'b0;
	logic                  await_drain = 1'b0;
	int                    burst_left = 0;
	int                    gap_left = 0;
	logic [15:0]           stall_bits = '0;
	logic [5:0]            stall_age = '0;
	int                    errors = 0;
	int                    tick_count = 0;
	int                    check_count = 0;
	int                    hit_count = 0;
	int                    items_taken = 0;
	int                    drain_pauses = 0;
	int                    settings_used = 1;
	logic [FLAG_W-1:0]     flags_seen = '0;

	multi_key_click_event_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.pin_levels(pin_levels),
		.key_index(key_index),
		.event_mask(event_mask),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.key_flags(key_flags)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Predict the result of one item and advance the key state machines
	function automatic click_result_t apply_item(input click_item_t it);
		click_result_t r;
		logic [FLAG_W-1:0] f;
		logic pressed;
		r = '0;
		if (it.func == FUNC_TICK) begin
			tick_count++;
			for (int k = 0; k < NUM_KEYS; k++)
				if (cnt_left[k] != '0) cnt_left[k]--;
			divider = divider + PER_W'(1);
			if (divider >= period_setting) begin
				divider = '0;
				for (int k = 0; k < NUM_KEYS; k++) begin
					pressed = !it.pins[k];
					f = key_events[k];
					f[EV_HOLD_BIT] = pressed;
					if (pressed && !prev_pressed[k]) f[EV_DOWN_BIT] = 1'b1;
					if (!pressed && prev_pressed[k]) f[EV_UP_BIT] = 1'b1;
					prev_pressed[k] = pressed;
					case (key_phase[k])
					PH_PRESSED: begin
						if (!pressed) begin
							cnt_left[k] = double_ticks;
							key_phase[k] = PH_WAIT_SECOND;
						end else if (cnt_left[k] == '0) begin
							cnt_left[k] = repeat_ticks;
							f[EV_LONG_BIT] = 1'b1;
							key_phase[k] = PH_REPEATING;
						end
					end
					PH_WAIT_SECOND: begin
						if (pressed) begin
							f[EV_DOUBLE_BIT] = 1'b1;
							key_phase[k] = PH_SECOND_HELD;
						end else if (cnt_left[k] == '0) begin
							f[EV_SINGLE_BIT] = 1'b1;
							key_phase[k] = PH_IDLE;
						end
					end
					PH_SECOND_HELD: begin
						if (!pressed) key_phase[k] = PH_IDLE;
					end
					PH_REPEATING: begin
						if (!pressed) begin
							key_phase[k] = PH_IDLE;
						end else if (cnt_left[k] == '0) begin
							cnt_left[k] = repeat_ticks;
							f[EV_REPEAT_BIT] = 1'b1;
						end
					end
					default: begin
						if (pressed) begin
							cnt_left[k] = long_ticks;
							key_phase[k] = PH_PRESSED;
						end else begin
							key_phase[k] = PH_IDLE;
						end
					end
					endcase
					key_events[k] = f;
				end
			end
		end else begin
			// check: report flags as they were, clear the masked ones
			check_count++;
			f = key_events[it.key];
			r.key_flags = f;
			flags_seen |= f;
			if ((f & it.mask) != '0) begin
				if (it.mask != EV_HOLD_MASK) key_events[it.key] = f & ~it.mask;
				r.hit = 1'b1;
				hit_count++;
			end
		end
		return r;
	endfunction

	// Sender: one item per handshake, bursts separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			item_taken = 1'b0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if ($urandom_range(0, 59) == 0 || (drain_pauses == 0 && items_taken > 300))
					await_drain = 1'b1;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (await_drain && flags_expected.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				if (await_drain) drain_pauses++;
				await_drain = 1'b0;
				drive_item = pending_items.pop_front();
				func <= drive_item.func;
				pin_levels <= drive_item.pins;
				key_index <= drive_item.key;
				event_mask <= drive_item.mask;
				in_valid <= 1'b1;
				burst_left--;
			end
		end
	end

	// Receiver: stall follows a rotating pattern, reloaded each time the 6-bit age counter wraps
	always @(negedge clk) begin
		if (stall_age == '0) begin
			case ($urandom_range(0, 3))
			0: stall_bits = '0;
			1: stall_bits = 16'($urandom);
			2: stall_bits = 16'($urandom & $urandom);
			default: stall_bits = 16'($urandom | $urandom);
			endcase
		end
		stall_age = stall_age + 6'd1;
		out_stall <= arst_n ? stall_bits[0] : 1'b0;
		stall_bits = {stall_bits[0], stall_bits[15:1]};
	end

	// Monitor: check each result against the oldest prediction, predict each taken item
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (flags_expected.size() == 0) begin
					$error("result item with none expected: hit %0b key_flags %07b",
						hit, key_flags);
					errors++;
				end else begin
					want = flags_expected.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, hit);
						errors++;
					end
					if (key_flags !== want.key_flags) begin
						$error("key_flags: expected %07b, got %07b", want.key_flags,
							key_flags);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				item_taken = 1'b1;
				items_taken++;
				flags_expected.push_back(apply_item('{func, pin_levels, key_index,
					event_mask}));
			end
		end
	end

	task automatic push_item(input logic f, input logic [NUM_KEYS-1:0] pins,
			input logic [KEY_W-1:0] key, input logic [FLAG_W-1:0] mask);
		pending_items.push_back('{f, pins, key, mask});
	endtask

	// Block until every queued item has gone through and its result has come back
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || flags_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_LONG: long_ticks = CNT_W'(value);
		CFG_DOUBLE: double_ticks = CNT_W'(value);
		CFG_REPEAT: repeat_ticks = CNT_W'(value);
		default: period_setting = PER_W'(value);
		endcase
	endtask

	task automatic apply_settings(input int lp, input int dbl, input int rep, input int sp);
		set_register(CFG_LONG, lp);
		set_register(CFG_DOUBLE, dbl);
		set_register(CFG_REPEAT, rep);
		set_register(CFG_PERIOD, sp);
		settings_used++;
	endtask

	// Mostly press/release patterns timed around the current settings, some checks,
	// a little pure noise
	task automatic queue_traffic(input int count);
		logic [NUM_KEYS-1:0] lv;
		int hold_left [NUM_KEYS];
		int dur, sp, kind;
		logic [FLAG_W-1:0] mask;
		lv = '1;
		for (int k = 0; k < NUM_KEYS; k++) hold_left[k] = 0;
		sp = (period_setting == '0) ? 1 : int'(period_setting);
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				push_item(1'($urandom), NUM_KEYS'($urandom), KEY_W'($urandom),
					FLAG_W'($urandom));
			end else if (kind < 32) begin
				case ($urandom_range(0, 9))
				0: mask = '0;
				1: mask = EV_HOLD_MASK;
				2, 3, 4: mask = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
				5, 6: mask = ALL_FLAGS;
				default: mask = FLAG_W'($urandom);
				endcase
				push_item(FUNC_CHECK, NUM_KEYS'($urandom), KEY_W'($urandom), mask);
			end else begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (hold_left[k] == 0) begin
						lv[k] = !lv[k];
						if (!lv[k]) begin
							// pressed: a short click or a hold past the long press
							if ($urandom_range(0, 2) != 0)
								dur = $urandom_range(1, 2 * sp);
							else
								dur = int'(long_ticks) + sp * $urandom_range(1, 3)
									+ int'(repeat_ticks) * $urandom_range(0, 3);
						end else begin
							// released: inside or beyond the double-click window
							if ($urandom_range(0, 1) == 0)
								dur = $urandom_range(1, int'(double_ticks) + 2 * sp);
							else
								dur = int'(double_ticks) + sp * $urandom_range(2, 5);
						end
						hold_left[k] = (dur > 250) ? 250 : dur;
					end else begin
						hold_left[k]--;
					end
				end
				push_item(FUNC_TICK, lv, KEY_W'($urandom), FLAG_W'($urandom));
			end
		end
	endtask

	initial begin
		// predicted state after reset
		long_ticks = LONG_RST;
		double_ticks = DOUBLE_RST;
		repeat_ticks = REPEAT_RST;
		period_setting = PERIOD_RST;
		divider = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			prev_pressed[k] = 1'b0;
			key_phase[k] = PH_IDLE;
			cnt_left[k] = '0;
			key_events[k] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: empty flags, all pressed, empty and hold-only masks
		push_item(FUNC_CHECK, 4'hF, 2'd0, ALL_FLAGS);
		push_item(FUNC_TICK, 4'h0, 2'd3, ALL_FLAGS);
		push_item(FUNC_TICK, 4'h0, 2'd0, '0);
		push_item(FUNC_CHECK, 4'h0, 2'd1, '0);
		push_item(FUNC_CHECK, 4'h0, 2'd1, EV_HOLD_MASK);
		push_item(FUNC_CHECK, 4'hF, 2'd1, EV_HOLD_MASK);
		push_item(FUNC_CHECK, 4'h0, 2'd2, ALL_FLAGS);
		push_item(FUNC_TICK, 4'hF, 2'd0, '0);
		push_item(FUNC_TICK, 4'hF, 2'd0, '0);
		push_item(FUNC_CHECK, 4'hF, 2'd3, DOWN_FLAG | UP_FLAG);
		push_item(FUNC_CHECK, 4'hF, 2'd3, ALL_FLAGS);
		wait_idle();

		// directed, zero tick counts and a sample period of zero
		apply_settings(0, 0, 0, 0);
		push_item(FUNC_TICK, 4'b1110, 2'd0, '0);
		push_item(FUNC_TICK, 4'b1110, 2'd0, '0);
		push_item(FUNC_TICK, 4'b1110, 2'd0, '0);
		push_item(FUNC_CHECK, 4'b1110, 2'd0, ALL_FLAGS);
		push_item(FUNC_TICK, 4'hF, 2'd0, '0);
		push_item(FUNC_TICK, 4'b1110, 2'd0, '0);
		push_item(FUNC_TICK, 4'hF, 2'd0, '0);
		push_item(FUNC_TICK, 4'hF, 2'd0, '0);
		push_item(FUNC_CHECK, 4'hF, 2'd0, SINGLE_FLAG);
		push_item(FUNC_TICK, 4'b0110, 2'd0, '0);
		push_item(FUNC_TICK, 4'b1111, 2'd0, '0);
		push_item(FUNC_TICK, 4'b0110, 2'd0, '0);
		push_item(FUNC_CHECK, 4'hF, 2'd3, DOUBLE_FLAG);
		wait_idle();

		// random phases, each under its own register settings
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: begin
				apply_settings(65535, 65535, 65535, 15);
				queue_traffic(80);
			end
			1: begin
				apply_settings(0, 0, 0, 1);
				queue_traffic(150);
			end
			default: begin
				apply_settings($urandom_range(0, 40), $urandom_range(0, 12),
					$urandom_range(0, 6),
					($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3));
				queue_traffic(185);
			end
			endcase
			wait_idle();
		end

		$display("Run covered %0d ticks and %0d checks (%0d hits) under %0d register settings.",
			tick_count, check_count, hit_count, settings_used);
		$display("Flags seen set on checks: %07b; sender paused for a full drain %0d times.",
			flags_seen, drain_pauses);
		if (errors == 0 && flags_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
